FILE: rtl/fmmp_pkg.sv
package fmmp_pkg;

    // Rule table geometry
    localparam int RULE_DEPTH = 16;
    localparam int ADDR_W     = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RULE_DEPTH + 1);
    localparam int ROM_RULES  = 9;
    localparam int ROM_IDX_W  = $clog2(ROM_RULES);
    localparam int SCAN_W     = $clog2((RULE_DEPTH > ROM_RULES) ? RULE_DEPTH : ROM_RULES);

    // Field enable bits of a rule
    localparam logic [3:0] EN_HOOK  = 4'h1;
    localparam logic [3:0] EN_MASK  = 4'h2;
    localparam logic [3:0] EN_MAGIC = 4'h4;
    localparam logic [3:0] EN_UID   = 4'h8;

    typedef enum logic [1:0] {
        REQ_MATCH  = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_COMMIT = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic        action;
        logic [3:0]  enables;
        logic [1:0]  hook;
        logic [3:0]  mask;
        logic [31:0] magic;
        logic [31:0] uid;
    } t_rule;

    // Built-in default rule set
    function automatic t_rule rom_rule(input logic [ROM_IDX_W-1:0] idx);
        t_rule r;
        r = '0;
        case (idx)
            ROM_IDX_W'(0): begin r.enables = EN_MAGIC; r.magic = 32'h0000_9fa0; end
            ROM_IDX_W'(1): begin r.enables = EN_MAGIC; r.magic = 32'h6265_6572; end
            ROM_IDX_W'(2): begin r.enables = EN_MAGIC; r.magic = 32'h6462_6720; end
            ROM_IDX_W'(3): begin r.enables = EN_MAGIC; r.magic = 32'h0102_1994; end
            ROM_IDX_W'(4): begin r.enables = EN_MAGIC; r.magic = 32'h7363_6673; end
            ROM_IDX_W'(5): begin r.enables = EN_MAGIC; r.magic = 32'hf97c_ff8c; end
            ROM_IDX_W'(6): begin
                r.action = 1'b1; r.enables = EN_HOOK | EN_MASK;
                r.hook = 2'd0; r.mask = 4'h1;
            end
            ROM_IDX_W'(7): begin
                r.action = 1'b1; r.enables = EN_HOOK | EN_MASK;
                r.hook = 2'd1; r.mask = 4'h1;
            end
            ROM_IDX_W'(8): begin
                r.action = 1'b1; r.enables = EN_HOOK | EN_MASK | EN_UID;
                r.hook = 2'd2; r.mask = 4'h4;
            end
            default: r = '0;  // never scanned
        endcase
        return r;
    endfunction

    function automatic logic rule_agrees(
        input t_rule       r,
        input logic [1:0]  hook,
        input logic [3:0]  mask,
        input logic [31:0] magic,
        input logic [31:0] uid
    );
        logic ok;
        ok = 1'b1;
        if (((r.enables & EN_HOOK)  != 4'h0) && (r.hook  != hook))  ok = 1'b0;
        if (((r.enables & EN_MASK)  != 4'h0) && (r.mask  != mask))  ok = 1'b0;
        if (((r.enables & EN_MAGIC) != 4'h0) && (r.magic != magic)) ok = 1'b0;
        if (((r.enables & EN_UID)   != 4'h0) && (r.uid   != uid))   ok = 1'b0;
        return ok;
    endfunction

endpackage

FILE: rtl/fmmp_if.sv
interface fmmp_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [1:0]  hook_code;
    logic [3:0]  access_mask;
    logic [31:0] fs_magic;
    logic [31:0] user_id;
    logic        rule_action;
    logic [3:0]  rule_enables;

    modport source (
        output valid, req_type, hook_code, access_mask, fs_magic, user_id,
               rule_action, rule_enables,
        input  ready
    );
    modport sink (
        input  valid, req_type, hook_code, access_mask, fs_magic, user_id,
               rule_action, rule_enables,
        output ready
    );
endinterface

interface fmmp_rsp_if;
    logic       valid;
    logic       ready;
    logic       measure;
    logic [1:0] status;

    modport source (output valid, measure, status, input ready);
    modport sink   (input valid, measure, status, output ready);
endinterface

FILE: rtl/first_match_measure_policy.sv
// A transaction is accepted only in S_IDLE and goes on to S_DONE, through S_SCAN for a match
// that has rules to scan. S_SCAN compares one rule per cycle: up to 16 loaded rules, read
// ahead from the rule memory, or the built-in default set. S_DONE holds the result until the
// output register is free, so no new transaction is taken before the last one has left S_DONE.
// Reset (i_rst_n low, synchronous) empties the loaded table count, clears commit, the
// default-rules register and all handshake state; memory is not cleared.
module first_match_measure_policy (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    fmmp_req_if.sink         i_req,
    fmmp_rsp_if.source       o_rsp
);
    import fmmp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // Control state
    t_state              r_state, n_state;
    logic                r_use_default;
    logic                r_committed, n_committed;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [SCAN_W-1:0]   r_idx, n_idx;
    logic [SCAN_W-1:0]   r_last_idx, n_last_idx;
    logic                r_from_rom, n_from_rom;

    // Latched request fields for the scan
    logic [1:0]          r_hook;
    logic [3:0]          r_mask;
    logic [31:0]         r_magic;
    logic [31:0]         r_uid;

    // Result waiting for the output register
    logic                r_res_measure, n_res_measure;
    t_status             r_res_status, n_res_status;

    // Output register
    logic                r_out_valid;
    logic                r_out_measure;
    t_status             r_out_status;

    // Rule memory: one write port and one read port, registered read data
    t_rule               mem [RULE_DEPTH];
    t_rule               r_rd_data;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    t_rule               wr_rule;

    logic                accept;
    logic                out_free;
    t_rule               cur_rule;
    logic                hit;
    logic                last;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    // Take a new transaction whenever no item is in flight; the output register
    // may still hold the previous result.
    assign i_req.ready = (r_state == S_IDLE);

    assign wr_rule = '{
        action:  i_req.rule_action,
        enables: i_req.rule_enables,
        hook:    i_req.hook_code,
        mask:    i_req.access_mask,
        magic:   i_req.fs_magic,
        uid:     i_req.user_id
    };

    // Read ahead: while rule r_idx is compared, fetch rule r_idx + 1.
    // Adds only happen before commit and loaded scans only after, so a read
    // never overlaps a pending write to the same entry.
    always_comb begin
        if (r_state == S_SCAN) begin
            rd_addr = ADDR_W'(SCAN_W'(r_idx + SCAN_W'(1)));
        end else begin
            rd_addr = '0;
        end
    end

    assign cur_rule = r_from_rom ? rom_rule(r_idx[ROM_IDX_W-1:0]) : r_rd_data;
    assign hit      = rule_agrees(cur_rule, r_hook, r_mask, r_magic, r_uid);
    assign last     = (r_idx == r_last_idx);

    always_comb begin
        n_state       = r_state;
        n_committed   = r_committed;
        n_count       = r_count;
        n_idx         = r_idx;
        n_last_idx    = r_last_idx;
        n_from_rom    = r_from_rom;
        n_res_measure = r_res_measure;
        n_res_status  = r_res_status;
        wr_en         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_measure = 1'b0;
                    n_res_status  = ST_OK;
                    n_idx         = '0;
                    n_state       = S_DONE;
                    unique case (t_req_type'(i_req.req_type))
                        REQ_MATCH: begin
                            if (r_committed) begin
                                // Scan the loaded table unless it is empty
                                if (r_count != '0) begin
                                    n_from_rom = 1'b0;
                                    n_last_idx = SCAN_W'(r_count - CNT_W'(1));
                                    n_state    = S_SCAN;
                                end
                            end else if (r_use_default) begin
                                n_from_rom = 1'b1;
                                n_last_idx = SCAN_W'(ROM_RULES - 1);
                                n_state    = S_SCAN;
                            end
                        end
                        REQ_ADD: begin
                            if (r_committed) begin
                                n_res_status = ST_REFUSED;
                            end else if (r_count >= CNT_W'(RULE_DEPTH)) begin
                                n_res_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        REQ_COMMIT: begin
                            if (r_committed) begin
                                n_res_status = ST_REFUSED;
                            end else begin
                                n_committed = 1'b1;
                            end
                        end
                        REQ_CLEAR: begin
                            n_count = '0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // First agreeing rule wins; no agreement answers 0
                if (hit) begin
                    n_res_measure = cur_rule.action;
                    n_state       = S_DONE;
                end else if (last) begin
                    n_res_measure = 1'b0;
                    n_state       = S_DONE;
                end else begin
                    n_idx = SCAN_W'(r_idx + SCAN_W'(1));
                end
            end
            S_DONE: begin
                // Hold the result until the output register can take it
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_use_default <= 1'b0;
            r_committed   <= 1'b0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_committed <= n_committed;
            r_count     <= n_count;
            if (i_cfg_we) begin
                r_use_default <= i_cfg_wdata;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_last_idx    <= n_last_idx;
        r_from_rom    <= n_from_rom;
        r_res_measure <= n_res_measure;
        r_res_status  <= n_res_status;
        if (accept) begin
            r_hook  <= i_req.hook_code;
            r_mask  <= i_req.access_mask;
            r_magic <= i_req.fs_magic;
            r_uid   <= i_req.user_id;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_measure <= r_res_measure;
            r_out_status  <= r_res_status;
        end
    end

    // Rule memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[ADDR_W-1:0]] <= wr_rule;
        end
        r_rd_data <= mem[rd_addr];
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.measure = r_out_measure;
    assign o_rsp.status  = r_out_status;

    // Commit is sticky until reset
    a_commit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_committed |=> r_committed)
        else $error("commit flag dropped");

    // After commit the loaded table never grows
    a_no_grow_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_committed |=> (r_count <= $past(r_count)))
        else $error("rule count grew after commit");

    // Fill count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RULE_DEPTH))
        else $error("rule count beyond table depth");

    // A scan never runs past its last rule
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_last_idx))
        else $error("scan index beyond last rule");

endmodule

FILE: tb/sv/tb_first_match_measure_policy.sv
module tb_first_match_measure_policy;
    import fmmp_pkg::*;

    // Cycles without any accepted transaction before the run is declared hung.
    // The slowest correct wait is a full 16-rule scan plus a long receiver stall.
    localparam int STALL_LIMIT = 4000;
    // Settling time after the last result: longer than the longest scan.
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        t_req_type   kind;
        logic [1:0]  hook;
        logic [3:0]  mask;
        logic [31:0] magic;
        logic [31:0] uid;
        logic        action;
        logic [3:0]  enables;
    } t_policy_req;

    typedef struct packed {
        logic    measure;
        t_status status;
    } t_policy_verdict;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    fmmp_req_if req_if ();
    fmmp_rsp_if rsp_if ();

    first_match_measure_policy u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // ------------------------------------------------------------------
    // Policy shadow: built-in set, loaded table, commit flag, register
    // ------------------------------------------------------------------
    t_rule dflt_rules [ROM_RULES];
    t_rule rule_tbl [RULE_DEPTH];
    int    rule_count;
    logic  policy_live;
    logic  default_rules_on;

    // Pending request transactions and verdicts still owed by the block
    t_policy_req     pending_q [$];
    t_policy_verdict verdict_q [$];

    // Stimulus side: rules believed loaded, used as templates for probes
    t_rule rule_pool [$];
    logic  gen_live;
    int    gen_total;

    int   src_idle_pct;
    int   snk_idle_pct;
    logic req_taken;
    int   stall_cycles;
    int   fail_count;

    int n_match, n_hit, n_add_ok, n_full, n_refused, n_commit, n_clear;

    function automatic t_rule mk_rule(logic act, logic [3:0] en, logic [1:0] hook,
                                      logic [3:0] mask, logic [31:0] magic,
                                      logic [31:0] uid);
        t_rule r;
        r.action  = act;
        r.enables = en;
        r.hook    = hook;
        r.mask    = mask;
        r.magic   = magic;
        r.uid     = uid;
        return r;
    endfunction

    // A rule agrees when every field it enables equals the request
    function automatic logic fields_agree(t_rule r, t_policy_req rq);
        if ((r.enables & EN_HOOK) != 4'h0 && r.hook != rq.hook) return 1'b0;
        if ((r.enables & EN_MASK) != 4'h0 && r.mask != rq.mask) return 1'b0;
        if ((r.enables & EN_MAGIC) != 4'h0 && r.magic != rq.magic) return 1'b0;
        if ((r.enables & EN_UID) != 4'h0 && r.uid != rq.uid) return 1'b0;
        return 1'b1;
    endfunction

    // Apply one accepted request to the shadow policy and return its verdict
    function automatic t_policy_verdict judge_request(t_policy_req rq);
        t_policy_verdict v;
        logic found;
        int k;
        v.measure = 1'b0;
        v.status  = ST_OK;
        found     = 1'b0;
        case (rq.kind)
            REQ_MATCH: begin
                n_match++;
                if (policy_live) begin
                    for (k = 0; k < rule_count; k++) begin
                        if (!found && fields_agree(rule_tbl[k], rq)) begin
                            v.measure = rule_tbl[k].action;
                            found = 1'b1;
                        end
                    end
                end else if (default_rules_on) begin
                    for (k = 0; k < ROM_RULES; k++) begin
                        if (!found && fields_agree(dflt_rules[k], rq)) begin
                            v.measure = dflt_rules[k].action;
                            found = 1'b1;
                        end
                    end
                end
                if (v.measure) n_hit++;
            end
            REQ_ADD: begin
                if (policy_live) begin
                    v.status = ST_REFUSED;
                    n_refused++;
                end else if (rule_count >= RULE_DEPTH) begin
                    v.status = ST_FULL;
                    n_full++;
                end else begin
                    rule_tbl[rule_count] = mk_rule(rq.action, rq.enables, rq.hook, rq.mask,
                                                   rq.magic, rq.uid);
                    rule_count++;
                    n_add_ok++;
                end
            end
            REQ_COMMIT: begin
                if (policy_live) begin
                    v.status = ST_REFUSED;
                    n_refused++;
                end else begin
                    policy_live = 1'b1;
                    n_commit++;
                end
            end
            default: begin
                rule_count = 0;
                n_clear++;
            end
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders: push request transactions onto the pending queue
    // ------------------------------------------------------------------
    function automatic void queue_req(t_req_type kind, logic [1:0] hook, logic [3:0] mask,
                                      logic [31:0] magic, logic [31:0] uid, logic act,
                                      logic [3:0] en);
        t_policy_req rq;
        rq.kind    = kind;
        rq.hook    = hook;
        rq.mask    = mask;
        rq.magic   = magic;
        rq.uid     = uid;
        rq.action  = act;
        rq.enables = en;
        pending_q.push_back(rq);
        gen_total++;
    endfunction

    // Unused fields of a match carry random values; the block must ignore them
    function automatic void queue_match(logic [1:0] hook, logic [3:0] mask,
                                        logic [31:0] magic, logic [31:0] uid);
        queue_req(REQ_MATCH, hook, mask, magic, uid, 1'($urandom_range(1)),
                  4'($urandom_range(15)));
    endfunction

    function automatic void queue_add(logic act, logic [3:0] en, logic [1:0] hook,
                                      logic [3:0] mask, logic [31:0] magic, logic [31:0] uid);
        if (!gen_live && rule_pool.size() < RULE_DEPTH)
            rule_pool.push_back(mk_rule(act, en, hook, mask, magic, uid));
        queue_req(REQ_ADD, hook, mask, magic, uid, act, en);
    endfunction

    // Commit or clear, with noise on every payload field
    function automatic void queue_op(t_req_type kind);
        if (kind == REQ_COMMIT) gen_live = 1'b1;
        if (kind == REQ_CLEAR && !gen_live) rule_pool.delete();
        queue_req(kind, 2'($urandom_range(3)), 4'($urandom_range(15)), $urandom, $urandom,
                  1'($urandom_range(1)), 4'($urandom_range(15)));
    endfunction

    function automatic logic [31:0] rand_magic();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 25) return dflt_rules[$urandom_range(5)].magic;
        if (r < 33) return 32'h0000_0000;
        if (r < 41) return 32'hffff_ffff;
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_uid();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'd1000;
            3: return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [3:0] rand_mask();
        if ($urandom_range(1) == 0) return 4'(1 << $urandom_range(3));
        return 4'($urandom_range(15));
    endfunction

    function automatic void queue_random_add();
        queue_add(1'($urandom_range(1)), 4'($urandom_range(15)), 2'($urandom_range(3)),
                  rand_mask(), rand_magic(), rand_uid());
    endfunction

    // Match aimed at a known rule (loaded or built-in) or at random fields, sometimes nudged off it
    function automatic void queue_probe();
        t_rule tpl;
        int unsigned pick;
        pick = $urandom_range(99);
        if (rule_pool.size() != 0 && pick < (gen_live ? 65 : 20))
            tpl = rule_pool[$urandom_range(rule_pool.size() - 1)];
        else if (pick < (gen_live ? 75 : 70))
            tpl = dflt_rules[$urandom_range(ROM_RULES - 1)];
        else
            tpl = mk_rule(1'b0, 4'h0, 2'($urandom_range(3)), 4'($urandom_range(15)),
                          $urandom, $urandom);
        if ($urandom_range(99) < 30) begin
            case ($urandom_range(3))
                0: tpl.hook = 2'($urandom_range(3));
                1: tpl.mask = rand_mask();
                2: tpl.magic = rand_magic();
                default: tpl.uid = rand_uid();
            endcase
        end
        queue_match(tpl.hook, tpl.mask, tpl.magic, tpl.uid);
    endfunction

    // Random traffic: before commit probes, adds (some in bursts, so the table fills up) and
    // clears; after commit mostly probes plus refused adds and commits, clears if allow_clear
    function automatic void queue_traffic(int n, logic allow_clear);
        int start;
        int unsigned r;
        start = gen_total;
        while (gen_total - start < n) begin
            r = $urandom_range(99);
            if (!gen_live) begin
                if (r < 50) queue_probe();
                else if (r < 57) repeat ($urandom_range(20, 1)) queue_random_add();
                else if (r < 95) queue_random_add();
                else queue_op(REQ_CLEAR);
            end else begin
                if (r < 84) queue_probe();
                else if (r < 92) queue_random_add();
                else if (r < 97 || !allow_clear) queue_op(REQ_COMMIT);
                else queue_op(REQ_CLEAR);
            end
        end
    endfunction

    // Hold until nothing is pending, nothing is offered and no verdict is owed
    task automatic settle_policy();
        do @(posedge clk);
        while (pending_q.size() != 0 || req_if.valid || verdict_q.size() != 0);
    endtask

    // Write the default-rules register; call only while the block is idle
    task automatic write_default_rules(logic v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        default_rules_on = v;
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge. Advance to the next pending
    // transaction once the current one is taken; hold valid and payload
    // steady while the block stalls; idle at random between transactions.
    // ------------------------------------------------------------------
    always @(negedge clk) begin : drive_req
        t_policy_req nxt;
        if (rst_n) begin
            rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            if (!req_if.valid || req_taken) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt = pending_q.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.req_type     <= nxt.kind;
                    req_if.hook_code    <= nxt.hook;
                    req_if.access_mask  <= nxt.mask;
                    req_if.fs_magic     <= nxt.magic;
                    req_if.user_id      <= nxt.uid;
                    req_if.rule_action  <= nxt.action;
                    req_if.rule_enables <= nxt.enables;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Capture each accepted request transaction and predict its verdict.
    always @(posedge clk) begin : accept_req
        t_policy_req seen;
        if (rst_n && req_if.valid && req_if.ready) begin
            seen.kind    = t_req_type'(req_if.req_type);
            seen.hook    = req_if.hook_code;
            seen.mask    = req_if.access_mask;
            seen.magic   = req_if.fs_magic;
            seen.uid     = req_if.user_id;
            seen.action  = req_if.rule_action;
            seen.enables = req_if.rule_enables;
            verdict_q.push_back(judge_request(seen));
            req_taken <= 1'b1;
        end else begin
            req_taken <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare every accepted response with the oldest verdict.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : check_rsp
        t_policy_verdict want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (verdict_q.size() == 0) begin
                $error("response with nothing outstanding: measure %0d status %0d",
                       rsp_if.measure, rsp_if.status);
                fail_count++;
            end else begin
                want = verdict_q.pop_front();
                if (rsp_if.measure !== want.measure) begin
                    $error("measure mismatch: expected %0d, got %0d",
                           want.measure, rsp_if.measure);
                    fail_count++;
                end
                if (rsp_if.status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, rsp_if.status);
                    fail_count++;
                end
            end
        end
    end

    // Count cycles in which neither side moves a transaction
    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge clk);
        $display("tb_first_match_measure_policy: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial begin
        int n_rules;

        // Drive every input to a known value from time zero
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = 1'b0;
        req_if.valid        = 1'b0;
        req_if.req_type     = REQ_MATCH;
        req_if.hook_code    = 2'd0;
        req_if.access_mask  = 4'h0;
        req_if.fs_magic     = 32'h0;
        req_if.user_id      = 32'h0;
        req_if.rule_action  = 1'b0;
        req_if.rule_enables = 4'h0;
        rsp_if.ready        = 1'b0;
        req_taken           = 1'b0;
        stall_cycles        = 0;
        fail_count          = 0;
        rule_count          = 0;
        policy_live         = 1'b0;
        default_rules_on    = 1'b0;
        gen_live            = 1'b0;
        gen_total           = 0;
        n_match = 0; n_hit = 0; n_add_ok = 0; n_full = 0;
        n_refused = 0; n_commit = 0; n_clear = 0;

        // Built-in set: six filesystems excluded, then three measuring hooks
        dflt_rules[0] = mk_rule(1'b0, EN_MAGIC, 2'd0, 4'h0, 32'h0000_9fa0, 32'h0);
        dflt_rules[1] = mk_rule(1'b0, EN_MAGIC, 2'd0, 4'h0, 32'h6265_6572, 32'h0);
        dflt_rules[2] = mk_rule(1'b0, EN_MAGIC, 2'd0, 4'h0, 32'h6462_6720, 32'h0);
        dflt_rules[3] = mk_rule(1'b0, EN_MAGIC, 2'd0, 4'h0, 32'h0102_1994, 32'h0);
        dflt_rules[4] = mk_rule(1'b0, EN_MAGIC, 2'd0, 4'h0, 32'h7363_6673, 32'h0);
        dflt_rules[5] = mk_rule(1'b0, EN_MAGIC, 2'd0, 4'h0, 32'hf97c_ff8c, 32'h0);
        dflt_rules[6] = mk_rule(1'b1, EN_HOOK | EN_MASK, 2'd0, 4'h1, 32'h0, 32'h0);
        dflt_rules[7] = mk_rule(1'b1, EN_HOOK | EN_MASK, 2'd1, 4'h1, 32'h0, 32'h0);
        dflt_rules[8] = mk_rule(1'b1, EN_HOOK | EN_MASK | EN_UID, 2'd2, 4'h4, 32'h0, 32'h0);

        // First stretch: sender rarely idles, receiver mostly stalls
        src_idle_pct = 7;
        snk_idle_pct = 73;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty active set with the register at its reset value
        queue_match(2'd0, 4'h1, 32'h0000_9fa0, 32'h0);
        settle_policy();

        // Directed: built-in set, first match wins over later measuring rules
        write_default_rules(1'b1);
        queue_match(2'd0, 4'h1, 32'h0000_9fa0, 32'h0);
        queue_match(2'd0, 4'h1, 32'h0000_0000, 32'h0);
        queue_match(2'd1, 4'h1, 32'hffff_ffff, 32'hffff_ffff);
        queue_match(2'd2, 4'h4, 32'h0000_0000, 32'h0);
        queue_match(2'd2, 4'h4, 32'h0000_0000, 32'hffff_ffff);
        queue_match(2'd3, 4'hf, 32'hffff_ffff, 32'hffff_ffff);
        queue_match(2'd1, 4'h1, 32'hf97c_ff8c, 32'h0);
        // Loaded rules stay inactive before commit; clear empties the table
        queue_add(1'b1, 4'hf, 2'd3, 4'hf, 32'hffff_ffff, 32'hffff_ffff);
        queue_add(1'b0, 4'h0, 2'd0, 4'h0, 32'h0, 32'h0);
        queue_match(2'd3, 4'hf, 32'hffff_ffff, 32'hffff_ffff);
        queue_op(REQ_CLEAR);
        queue_add(1'b1, 4'hf, 2'd2, 4'h8, 32'h1234_5678, 32'd1000);

        // Random traffic before commit; drain between chunks so the sender
        // pauses with every verdict delivered
        repeat (3) begin
            queue_traffic(50, 1'b0);
            settle_policy();
        end
        write_default_rules(1'b0);
        queue_traffic(60, 1'b0);
        settle_policy();

        // Second stretch: sender mostly idles, receiver rarely stalls
        src_idle_pct = 73;
        snk_idle_pct = 7;
        write_default_rules(1'b1);
        queue_traffic(80, 1'b0);
        settle_policy();

        // Load a fresh table and commit; a second commit and a late add are refused
        queue_op(REQ_CLEAR);
        n_rules = $urandom_range(RULE_DEPTH, 8);
        repeat (n_rules) queue_random_add();
        queue_op(REQ_COMMIT);
        queue_op(REQ_COMMIT);
        queue_random_add();
        queue_probe();
        repeat (3) begin
            queue_traffic(50, 1'b0);
            settle_policy();
        end

        // Third stretch: no idling; the register no longer matters once committed
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_default_rules(1'b0);
        queue_traffic(100, 1'b0);
        settle_policy();
        write_default_rules(1'b1);
        // Clear after commit: the active set goes empty for good
        queue_op(REQ_CLEAR);
        queue_probe();
        queue_random_add();
        queue_traffic(40, 1'b1);

        settle_policy();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d matches (%0d measured), %0d rules loaded,",
                 n_match, n_hit, n_add_ok);
        $display("%0d adds to a full table, %0d refused adds or commits, %0d commits, %0d clears",
                 n_full, n_refused, n_commit, n_clear);
        if (fail_count == 0)
            $display("tb_first_match_measure_policy: done, clean");
        else
            $display("tb_first_match_measure_policy: done, errors");
        $finish;
    end

endmodule
